[rtl/lrc_pkg.sv]
package lrc_pkg;

   // fixed field widths of the request and response transactions
   localparam int CMD_BITS      = 2;
   localparam int REQ_KEY_BITS  = 32;
   localparam int REQ_DATA_BITS = 64;
   localparam int USE_BITS      = 32;
   localparam int OCC_OUT_BITS  = 5;
   localparam int TOTAL_BITS    = 32;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_GET   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

   // sequencer states, one-hot
   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_UPDATE = 2'b10
   } state_type;

   // controls broadcast to every cell of the recency chain
   typedef struct packed {
      logic capture;   // latch the key compare result
      logic clear;     // drop every entry
   } cell_ctl_type;

endpackage

[rtl/lrc_if.sv]
// request channel
interface lrc_req_if import lrc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_BITS-1:0]      cmd;
   logic [REQ_KEY_BITS-1:0]  key;
   logic [REQ_DATA_BITS-1:0] entry_data;

   modport source (output valid, cmd, key, entry_data, input ready);
   modport sink   (input valid, cmd, key, entry_data, output ready);
endinterface

// response channel
interface lrc_rsp_if import lrc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic [REQ_DATA_BITS-1:0] data_out;
   logic [USE_BITS-1:0]      use_count;
   logic [OCC_OUT_BITS-1:0]  occupancy;
   logic [TOTAL_BITS-1:0]    hit_total;
   logic [TOTAL_BITS-1:0]    miss_total;

   modport source (output valid, hit, data_out, use_count, occupancy, hit_total, miss_total,
                   input ready);
   modport sink   (input valid, hit, data_out, use_count, occupancy, hit_total, miss_total,
                   output ready);
endinterface

[rtl/lrc_cell.sv]
// one recency position: holds an entry, compares it and takes its neighbor's on a shift
module lrc_cell import lrc_pkg::*; #(
   parameter int KEY_BITS     = 32,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctl_type            ctl,
   input  logic                    shift,
   input  logic [KEY_BITS-1:0]     cmp_key,
   input  logic                    prev_valid,
   input  logic [KEY_BITS-1:0]     prev_key,
   input  logic [PAYLOAD_BITS-1:0] prev_payload,
   input  logic [USE_BITS-1:0]     prev_uses,
   output logic                    valid,
   output logic [KEY_BITS-1:0]     key,
   output logic [PAYLOAD_BITS-1:0] payload,
   output logic [USE_BITS-1:0]     uses,
   output logic                    match
);

   logic                    valid_ff, valid_in;
   logic                    match_ff, match_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic [USE_BITS-1:0]     uses_ff, uses_in;

   // key compare against the incoming transaction
   assign match_in = ctl.capture ? (valid_ff && (key_ff == cmp_key)) : match_ff;

   // entry update: clear wins, else take the neighbor's entry on a shift
   always_comb begin
      valid_in   = valid_ff;
      key_in     = key_ff;
      payload_in = payload_ff;
      uses_in    = uses_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (shift) begin
         valid_in   = prev_valid;
         key_in     = prev_key;
         payload_in = prev_payload;
         uses_in    = prev_uses;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
      uses_ff    <= uses_in;
   end

   assign valid   = valid_ff;
   assign key     = key_ff;
   assign payload = payload_ff;
   assign uses    = uses_ff;
   assign match   = match_ff;

endmodule

[rtl/lru_record_cache.sv]
// a request is taken only in the idle state, and every cell latches its key compare;
// the update state then moves the recency chain and loads the response register,
// waiting while an earlier response stalls, so each transaction is finished before
// the next request is taken
// reset: synchronous, active high; empties every entry, zeroes the hit and miss totals
// and the occupancy, drops any pending response; no clearing pass is needed
module lru_record_cache import lrc_pkg::*; #(
   parameter int ENTRIES      = 16,
   parameter int KEY_BITS     = 32,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic      clock,
   input  logic      reset,
   lrc_req_if.sink   req_if,
   lrc_rsp_if.source rsp_if
);

   localparam int OCC_BITS = $clog2(ENTRIES + 1);

   state_type state_ff, state_in;

   // latched request
   logic [CMD_BITS-1:0]     cmd_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic [PAYLOAD_BITS-1:0] data_ff;

   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   logic [TOTAL_BITS-1:0] hit_total_ff, hit_total_in;
   logic [TOTAL_BITS-1:0] miss_total_ff, miss_total_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff;
   logic [REQ_DATA_BITS-1:0] rsp_data_ff;
   logic [USE_BITS-1:0]      rsp_uses_ff;

   logic accept, step;
   logic is_put, is_get, is_clear, hit, do_move;
   logic [KEY_BITS-1:0]     cmp_key;
   logic [KEY_BITS-1:0]     front_key;
   logic [PAYLOAD_BITS-1:0] front_payload;
   logic [USE_BITS-1:0]     front_uses;
   logic [PAYLOAD_BITS-1:0] sel_payload;
   logic [USE_BITS-1:0]     sel_uses;
   logic [ENTRIES-1:0]      valid_vec, match_vec, shift_vec;
   logic [KEY_BITS-1:0]     cell_key     [ENTRIES];
   logic [PAYLOAD_BITS-1:0] cell_payload [ENTRIES];
   logic [USE_BITS-1:0]     cell_uses    [ENTRIES];
   cell_ctl_type            cell_ctl;

   assign accept = req_if.valid && req_if.ready;
   assign step   = (state_ff == S_UPDATE) && (!rsp_valid_ff || rsp_if.ready);

   assign req_if.ready = (state_ff == S_IDLE);
   assign cmp_key      = KEY_BITS'(req_if.key);

   // sequencer: compare on accept, update the chain unless a response is stalled
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (accept) state_in = S_UPDATE;
         S_UPDATE: if (step) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      is_put   = 1'b0;
      is_get   = 1'b0;
      is_clear = 1'b0;
      case (cmd_ff)
         CMD_PUT:   is_put = 1'b1;
         CMD_GET:   is_get = 1'b1;
         CMD_CLEAR: is_clear = 1'b1;
         default:   ;
      endcase
   end

   // pick the matching entry, keys are unique among valid entries
   always_comb begin
      sel_payload = '0;
      sel_uses    = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         sel_payload = sel_payload | (match_vec[i] ? cell_payload[i] : '0);
         sel_uses    = sel_uses | (match_vec[i] ? cell_uses[i] : '0);
      end
   end

   assign hit     = |match_vec;
   assign do_move = step && (is_put || (is_get && hit));

   // new front entry of the chain
   assign front_key     = key_ff;
   assign front_payload = is_put ? data_ff : sel_payload;
   assign front_uses    = hit ? (sel_uses + USE_BITS'(1)) : USE_BITS'(1);

   assign cell_ctl.capture = accept;
   assign cell_ctl.clear   = step && is_clear;

   // recency chain, position 0 is most recent
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic                    prev_valid;
      logic [KEY_BITS-1:0]     prev_key;
      logic [PAYLOAD_BITS-1:0] prev_payload;
      logic [USE_BITS-1:0]     prev_uses;

      // on a hit only positions up to the hit one move, on an insert all of them
      assign shift_vec[i] = do_move && (hit ? (|(match_vec >> i)) : 1'b1);

      if (i == 0) begin : g_head
         assign prev_valid   = 1'b1;
         assign prev_key     = front_key;
         assign prev_payload = front_payload;
         assign prev_uses    = front_uses;
      end else begin : g_link
         assign prev_valid   = valid_vec[i-1];
         assign prev_key     = cell_key[i-1];
         assign prev_payload = cell_payload[i-1];
         assign prev_uses    = cell_uses[i-1];
      end

      lrc_cell #(
         .KEY_BITS     (KEY_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (cell_ctl),
         .shift        (shift_vec[i]),
         .cmp_key      (cmp_key),
         .prev_valid   (prev_valid),
         .prev_key     (prev_key),
         .prev_payload (prev_payload),
         .prev_uses    (prev_uses),
         .valid        (valid_vec[i]),
         .key          (cell_key[i]),
         .payload      (cell_payload[i]),
         .uses         (cell_uses[i]),
         .match        (match_vec[i])
      );
   end

   // occupancy and totals
   always_comb begin
      occ_in        = occ_ff;
      hit_total_in  = hit_total_ff;
      miss_total_in = miss_total_ff;
      if (step) begin
         if (is_clear) begin
            occ_in = '0;
         end else if (is_put && !hit && (occ_ff < OCC_BITS'(ENTRIES))) begin
            occ_in = occ_ff + OCC_BITS'(1);
         end
         if (is_get && hit) begin
            hit_total_in = hit_total_ff + TOTAL_BITS'(1);
         end
         if (is_get && !hit) begin
            miss_total_in = miss_total_ff + TOTAL_BITS'(1);
         end
      end
   end

   // response handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         hit_total_ff  <= '0;
         miss_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         hit_total_ff  <= hit_total_in;
         miss_total_ff <= miss_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_if.cmd;
         key_ff  <= cmp_key;
         data_ff <= PAYLOAD_BITS'(req_if.entry_data);
      end
      if (step) begin
         rsp_hit_ff  <= (is_put || is_get) && hit;
         rsp_data_ff <= (is_get && hit) ? REQ_DATA_BITS'(sel_payload) : '0;
         rsp_uses_ff <= (is_put || (is_get && hit)) ? front_uses : '0;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.hit        = rsp_hit_ff;
   assign rsp_if.data_out   = rsp_data_ff;
   assign rsp_if.use_count  = rsp_uses_ff;
   assign rsp_if.occupancy  = OCC_OUT_BITS'(occ_ff);
   assign rsp_if.hit_total  = hit_total_ff;
   assign rsp_if.miss_total = miss_total_ff;

   // valid entries always fill the front of the chain and match the occupancy count
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == occ_ff)
      else $error("occupancy count disagrees with valid entries");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_BITS'(ENTRIES))
      else $error("occupancy beyond entry count");

   // a key sits in at most one entry
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> $onehot0(match_vec))
      else $error("key matched in more than one entry");

   // a response appears only out of an update cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_UPDATE))
      else $error("response raised without an update");

endmodule

[test/tb_lru_record_cache.sv]
module tb_lru_record_cache;
   timeunit 1ns;
   timeprecision 1ps;

   import lrc_pkg::*;

   localparam int CACHE_ENTRIES = 16;
   localparam int KEY_POOL_SIZE = 22;
   localparam int HOLD_CYCLES   = 150;
   localparam int PRESSURE_ITEMS = 60;
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   // traffic phases: no idling, sender idle, receiver stalling, both lightly
   localparam int PHASE_ITEMS [4]      = '{300, 250, 250, 300};
   localparam int PHASE_SEND_IDLE [4]  = '{0, 88, 0, 7};
   localparam int PHASE_RECV_STALL [4] = '{0, 0, 88, 7};

   typedef struct packed {
      logic [CMD_BITS-1:0]      cmd;
      logic [REQ_KEY_BITS-1:0]  key;
      logic [REQ_DATA_BITS-1:0] entry_data;
   } cache_request_type;

   typedef struct packed {
      logic                     hit;
      logic [REQ_DATA_BITS-1:0] data_out;
      logic [USE_BITS-1:0]      use_count;
      logic [OCC_OUT_BITS-1:0]  occupancy;
      logic [TOTAL_BITS-1:0]    hit_total;
      logic [TOTAL_BITS-1:0]    miss_total;
   } cache_reply_type;

   logic clock = 1'b0;
   logic reset;

   lrc_req_if req_if ();
   lrc_rsp_if rsp_if ();

   lru_record_cache #(
      .ENTRIES      (CACHE_ENTRIES),
      .KEY_BITS     (REQ_KEY_BITS),
      .PAYLOAD_BITS (REQ_DATA_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // shadow copy of the cache contents
   logic                     line_live    [CACHE_ENTRIES];
   logic [REQ_KEY_BITS-1:0]  line_key     [CACHE_ENTRIES];
   logic [REQ_DATA_BITS-1:0] line_payload [CACHE_ENTRIES];
   logic [USE_BITS-1:0]      line_uses    [CACHE_ENTRIES];
   int unsigned              line_rank    [CACHE_ENTRIES];
   logic [TOTAL_BITS-1:0]    hit_count;
   logic [TOTAL_BITS-1:0]    miss_count;

   logic [REQ_KEY_BITS-1:0] key_pool [KEY_POOL_SIZE];

   cache_request_type request_backlog[$];
   cache_reply_type   expected_replies[$];

   int items_queued = 0;
   int reqs_sent    = 0;
   int reqs_done    = 0;
   int replies_seen = 0;
   int error_count  = 0;
   int n_puts = 0, n_evictions = 0, n_gets = 0, n_clears = 0, n_unused = 0;

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_request   = 1'b0;
   logic hold_off       = 1'b0;

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int live_count();
      int n;
      n = 0;
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (line_live[i]) n++;
      return n;
   endfunction

   // make a line most recent; live lines more recent than limit age by one
   function automatic void move_to_front(int slot, int unsigned limit);
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (i != slot && line_live[i] && line_rank[i] < limit)
            line_rank[i]++;
      line_rank[slot] = 0;
   endfunction

   // apply one transaction to the shadow cache and return the reply it produces
   function automatic cache_reply_type apply_request(cache_request_type rq);
      cache_reply_type rp;
      int              slot;
      int unsigned     limit;
      rp   = '0;
      slot = -1;
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (slot < 0 && line_live[i] && line_key[i] == rq.key)
            slot = i;
      case (rq.cmd)
         CMD_PUT: begin
            n_puts++;
            if (slot >= 0) begin
               rp.hit = 1'b1;
               line_payload[slot] = rq.entry_data;
               line_uses[slot]    = line_uses[slot] + 1'b1;
               move_to_front(slot, line_rank[slot]);
            end else begin
               if (live_count() < CACHE_ENTRIES) begin
                  // first free line
                  slot = 0;
                  while (slot < CACHE_ENTRIES - 1 && line_live[slot])
                     slot++;
                  limit = '1;
               end else begin
                  // evict the least recent line
                  slot = 0;
                  for (int i = 1; i < CACHE_ENTRIES; i++)
                     if (line_rank[i] > line_rank[slot])
                        slot = i;
                  limit = line_rank[slot];
                  n_evictions++;
               end
               line_live[slot] = 1'b0;
               move_to_front(slot, limit);
               line_live[slot]    = 1'b1;
               line_key[slot]     = rq.key;
               line_payload[slot] = rq.entry_data;
               line_uses[slot]    = USE_BITS'(1);
            end
            rp.use_count = line_uses[slot];
         end
         CMD_GET: begin
            n_gets++;
            if (slot >= 0) begin
               rp.hit = 1'b1;
               hit_count = hit_count + 1'b1;
               line_uses[slot] = line_uses[slot] + 1'b1;
               move_to_front(slot, line_rank[slot]);
               rp.data_out  = line_payload[slot];
               rp.use_count = line_uses[slot];
            end else begin
               miss_count = miss_count + 1'b1;
            end
         end
         CMD_CLEAR: begin
            n_clears++;
            for (int i = 0; i < CACHE_ENTRIES; i++)
               line_live[i] = 1'b0;
         end
         default: begin
            n_unused++;
         end
      endcase
      rp.occupancy  = OCC_OUT_BITS'(live_count());
      rp.hit_total  = hit_count;
      rp.miss_total = miss_count;
      return rp;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic void queue_item(logic [CMD_BITS-1:0] cmd, logic [REQ_KEY_BITS-1:0] key,
                                      logic [REQ_DATA_BITS-1:0] data);
      cache_request_type rq;
      rq.cmd        = cmd;
      rq.key        = key;
      rq.entry_data = data;
      request_backlog.push_back(rq);
      items_queued++;
   endfunction

   // mostly puts and gets over a small key pool so lines hit and get evicted
   function automatic void queue_random_item();
      int                      r;
      logic [CMD_BITS-1:0]     cmd;
      logic [REQ_KEY_BITS-1:0] key;
      r = $urandom_range(999);
      if (r < 470)
         cmd = CMD_PUT;
      else if (r < 960)
         cmd = CMD_GET;
      else if (r < 985)
         cmd = CMD_CLEAR;
      else
         cmd = CMD_UNUSED;
      if ($urandom_range(99) < 85)
         key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
      else
         key = $urandom;
      queue_item(cmd, key, {$urandom, $urandom});
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (replies_seen != items_queued)
         @(negedge clock);
      @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin : request_driver
      cache_request_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (reqs_done == reqs_sent) begin
         if (request_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            item = request_backlog.pop_front();
            req_if.valid      <= 1'b1;
            req_if.cmd        <= item.cmd;
            req_if.key        <= item.key;
            req_if.entry_data <= item.entry_data;
            reqs_sent         <= reqs_sent + 1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response ready, with random stalls and the long hold
   always @(negedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // long receiver hold, counted in cycles
   initial begin : receiver_hold
      wait (hold_request);
      @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off <= 1'b0;
   end

   // monitor: check each response transaction, predict each request transaction
   always @(posedge clock) begin : monitor
      cache_reply_type want;
      cache_request_type taken;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            replies_seen <= replies_seen + 1;
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual hit=%0b data=0x%0h",
                        $time, rsp_if.hit, rsp_if.data_out);
               error_count++;
            end else begin
               want = expected_replies.pop_front();
               check_field("hit",        want.hit,        rsp_if.hit);
               check_field("data_out",   want.data_out,   rsp_if.data_out);
               check_field("use_count",  want.use_count,  rsp_if.use_count);
               check_field("occupancy",  want.occupancy,  rsp_if.occupancy);
               check_field("hit_total",  want.hit_total,  rsp_if.hit_total);
               check_field("miss_total", want.miss_total, rsp_if.miss_total);
            end
         end
         if (req_if.valid && req_if.ready) begin
            taken.cmd        = req_if.cmd;
            taken.key        = req_if.key;
            taken.entry_data = req_if.entry_data;
            expected_replies.push_back(apply_request(taken));
            reqs_done <= reqs_done + 1;
         end
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      req_if.valid      = 1'b0;
      req_if.cmd        = CMD_PUT;
      req_if.key        = '0;
      req_if.entry_data = '0;
      rsp_if.ready      = 1'b0;
      reset             = 1'b1;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         line_live[i]    = 1'b0;
         line_key[i]     = '0;
         line_payload[i] = '0;
         line_uses[i]    = '0;
         line_rank[i]    = 0;
      end
      hit_count  = '0;
      miss_count = '0;
      for (int i = 0; i < KEY_POOL_SIZE; i++)
         key_pool[i] = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme keys and payloads, overwrite, unused code, fill, evict, clear
      queue_item(CMD_GET, '0, '1);
      queue_item(CMD_PUT, '0, '0);
      queue_item(CMD_PUT, '1, '1);
      queue_item(CMD_GET, '1, '0);
      queue_item(CMD_PUT, '0, 64'hA5A5_5A5A_0F0F_F0F0);
      queue_item(CMD_GET, '0, '0);
      queue_item(CMD_UNUSED, '1, '1);
      for (int k = 1; k <= CACHE_ENTRIES - 2; k++)
         queue_item(CMD_PUT, k, {$urandom, $urandom});
      // cache is full: the all-ones key is least recent and goes
      queue_item(CMD_PUT, 32'h0000_0100, '1);
      queue_item(CMD_GET, '1, '0);
      queue_item(CMD_CLEAR, '0, '0);
      queue_item(CMD_GET, '0, '0);
      queue_item(CMD_PUT, '0, 64'h1);
      wait_drained();

      // random phases
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = PHASE_SEND_IDLE[p];
         recv_stall_pct = PHASE_RECV_STALL[p];
         repeat (PHASE_ITEMS[p]) queue_random_item();
         wait_drained();
      end

      // receiver holds off while the sender keeps offering
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b1;
      repeat (PRESSURE_ITEMS) queue_random_item();
      wait_drained();

      repeat (10) @(negedge clock);
      if (expected_replies.size() != 0) begin
         $display("%0t: %0d responses missing, expected 0 outstanding, actual %0d",
                  $time, expected_replies.size(), expected_replies.size());
         error_count++;
      end
      $display("covered %0d transactions: %0d puts (%0d evictions), %0d gets (%0d hits, %0d misses),",
               items_queued, n_puts, n_evictions, n_gets, hit_count, miss_count);
      $display("  %0d clears, %0d unused codes; idle, stall and %0d-cycle hold phases, %0d errors",
               n_clears, n_unused, HOLD_CYCLES, error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
